/* rtl/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, codes, command and status types and calendar helpers for
// the Gregorian date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

    // field widths
    localparam int ACTION_W     = 2;
    localparam int AMOUNT_WIDTH = 16;
    localparam int DAY_W        = 5;
    localparam int MONTH_W      = 4;
    localparam int YEAR_W       = 14;
    localparam int STATUS_W     = 2;

    // calendar constants
    localparam int YEAR_MAX    = 9999;
    localparam int YEAR_RESET  = 1970;
    localparam int ERA_YEARS   = 400;
    localparam int CENTURY     = 100;
    localparam int MONTHS_YEAR = 12;
    localparam int MONTH_FEB   = 2;
    localparam int MONTH_JUL   = 7;
    localparam int FEB_LEAP    = 29;
    localparam int FEB_COMMON  = 28;
    localparam int SHORT_MONTH = 30;
    localparam int LONG_MONTH  = 31;
    localparam int COMMON_YEAR = 365;

    // year modulo 400 tracking
    localparam int MOD_W     = $clog2(ERA_YEARS);
    localparam int MOD_RESET = YEAR_RESET % ERA_YEARS;
    localparam int YLEN_W    = $clog2(COMMON_YEAR + 2);

    // reciprocal multipliers for the two constant divisions
    localparam int RECIP_SHIFT  = 21;
    localparam int RECIP_400    = (2 ** RECIP_SHIFT + ERA_YEARS - 1) / ERA_YEARS;
    localparam int RECIP_12     = (2 ** RECIP_SHIFT + MONTHS_YEAR - 1) / MONTHS_YEAR;
    localparam int RECIP_400_W  = $clog2(RECIP_400 + 1);
    localparam int RECIP_12_W   = $clog2(RECIP_12 + 1);
    localparam int ERA_Q_W      = $clog2((2 ** YEAR_W) / ERA_YEARS + 1);
    localparam int MPROD_W      = YEAR_W + RECIP_400_W;

    // month count arithmetic for month and year steps
    localparam int TOTAL_MAX = YEAR_MAX * MONTHS_YEAR + MONTHS_YEAR - 1;
    localparam int MONTHS_W  = $clog2(TOTAL_MAX + 1);
    localparam int SUM_W     = (AMOUNT_WIDTH > YEAR_W + 1 ? AMOUNT_WIDTH : YEAR_W + 1) + 1;
    localparam int TOTAL_W   = SUM_W + 4;
    localparam int DPROD_W   = MONTHS_W + RECIP_12_W;
    localparam int PROD_W    = DPROD_W > MPROD_W ? DPROD_W : MPROD_W;
    localparam int CMP_W     = AMOUNT_WIDTH > YLEN_W ? AMOUNT_WIDTH : YLEN_W;

    // stream payload layout
    localparam int IN_DAY_LSB    = AMOUNT_WIDTH;
    localparam int IN_MONTH_LSB  = IN_DAY_LSB + DAY_W;
    localparam int IN_YEAR_LSB   = IN_MONTH_LSB + MONTH_W;
    localparam int IN_FIELDS_W   = IN_YEAR_LSB + YEAR_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int OUT_MONTH_LSB = DAY_W;
    localparam int OUT_YEAR_LSB  = OUT_MONTH_LSB + MONTH_W;
    localparam int OUT_LEAP_LSB  = OUT_YEAR_LSB + YEAR_W;
    localparam int OUT_MLEN_LSB  = OUT_LEAP_LSB + 1;
    localparam int OUT_STAT_LSB  = OUT_MLEN_LSB + DAY_W;
    localparam int OUT_FIELDS_W  = OUT_STAT_LSB + STATUS_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_DAYS   = 2'd1,
        ACT_MONTHS = 2'd2,
        ACT_YEARS  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TOTAL,
        OP_DIV,
        OP_SPLIT,
        OP_MOD_MUL,
        OP_MOD_SUB,
        OP_CHECK,
        OP_FIX,
        OP_STEP,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;     // action of the transaction in progress
        logic    total_bad;  // month count outside the calendar range
        logic    n_zero;     // no days left to step
        logic    err;        // transaction already refused
    } t_dp_stat;

    // leap rule from the year modulo 400
    function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
        logic cent;
        cent = (ymod == MOD_W'(CENTURY)) || (ymod == MOD_W'(2 * CENTURY)) ||
               (ymod == MOD_W'(3 * CENTURY));
        return (ymod[1:0] == 2'b00) && !cent;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_W'(MONTH_FEB)) begin
            len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_COMMON);
        end else if (m <= MONTH_W'(MONTH_JUL)) begin
            len = m[0] ? DAY_W'(LONG_MONTH) : DAY_W'(SHORT_MONTH);
        end else begin
            len = m[0] ? DAY_W'(SHORT_MONTH) : DAY_W'(LONG_MONTH);
        end
        return len;
    endfunction

endpackage

/* rtl/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer for the date adder: takes one transaction at a time, walks the
// datapath through its operations and owns the output valid flag.
// ----------------------------------------------------------------------------
module gda_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  gda_pkg::t_action   i_action,
    input  gda_pkg::t_dp_stat  i_stat,
    output gda_pkg::t_dp_cmd   o_cmd,
    output logic               o_m_tvalid,
    input  logic               i_m_tready
);
    import gda_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_TOTAL   = 10'b00_0000_0010,
        S_DIV     = 10'b00_0000_0100,
        S_SPLIT   = 10'b00_0000_1000,
        S_MOD_MUL = 10'b00_0001_0000,
        S_MOD_SUB = 10'b00_0010_0000,
        S_CHECK   = 10'b00_0100_0000,
        S_FIX     = 10'b00_1000_0000,
        S_STEP    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // next state and datapath command
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_CAPTURE;
                    unique case (i_action)
                        ACT_LOAD:   n_state = S_MOD_MUL;
                        ACT_DAYS:   n_state = S_STEP;
                        ACT_MONTHS,
                        ACT_YEARS:  n_state = S_TOTAL;
                        default:    n_state = S_TOTAL;
                    endcase
                end
            end
            S_TOTAL: begin
                o_cmd.op = OP_TOTAL;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_state  = i_stat.total_bad ? S_DONE : S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.op = OP_SPLIT;
                n_state  = S_MOD_MUL;
            end
            S_MOD_MUL: begin
                o_cmd.op = OP_MOD_MUL;
                n_state  = S_MOD_SUB;
            end
            S_MOD_SUB: begin
                o_cmd.op = OP_MOD_SUB;
                n_state  = (i_stat.action == ACT_LOAD) ? S_CHECK : S_FIX;
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = S_DONE;
            end
            S_FIX: begin
                o_cmd.op = OP_FIX;
                n_state  = S_DONE;
            end
            S_STEP: begin
                if (i_stat.n_zero || i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_STEP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/gda_datapath.sv */
// ----------------------------------------------------------------------------
// gda_datapath
// Held date, working date, month count divider, year modulo 400 reduction,
// day stepper and the output data register.
// ----------------------------------------------------------------------------
module gda_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gda_pkg::t_dp_cmd                  i_cmd,
    input  gda_pkg::t_action                  i_action,
    input  logic [gda_pkg::IN_DATA_W-1:0]     i_data,
    output gda_pkg::t_dp_stat                 o_stat,
    output logic [gda_pkg::OUT_DATA_W-1:0]    o_data
);
    import gda_pkg::*;

    // held date
    logic [DAY_W-1:0]   r_day,   n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [MOD_W-1:0]   r_ymod,  n_ymod;

    // working date
    logic [DAY_W-1:0]   r_w_day,   n_w_day;
    logic [MONTH_W-1:0] r_w_month, n_w_month;
    logic [YEAR_W-1:0]  r_w_year,  n_w_year;
    logic [MOD_W-1:0]   r_w_ymod,  n_w_ymod;

    // transaction state
    t_action                         r_act,    n_act;
    t_status                         r_status, n_status;
    logic signed [AMOUNT_WIDTH-1:0]  r_amount, n_amount;
    logic                            r_dir,    n_dir;
    logic [AMOUNT_WIDTH-1:0]         r_n,      n_n;
    logic signed [TOTAL_W-1:0]       r_total,  n_total;
    logic [PROD_W-1:0]               r_prod,   n_prod;
    logic [OUT_DATA_W-1:0]           r_odata,  n_odata;

    // input unpacking
    logic signed [AMOUNT_WIDTH-1:0]  in_amount;
    logic [DAY_W-1:0]                in_day;
    logic [MONTH_W-1:0]              in_month;
    logic [YEAR_W-1:0]               in_year;

    assign in_amount = i_data[AMOUNT_WIDTH-1:0];
    assign in_day    = i_data[IN_DAY_LSB +: DAY_W];
    assign in_month  = i_data[IN_MONTH_LSB +: MONTH_W];
    assign in_year   = i_data[IN_YEAR_LSB +: YEAR_W];

    // calendar facts of the working date
    logic                 leap_w, leap_up, leap_dn, feb29, month_last;
    logic [MOD_W-1:0]     ymod_up, ymod_dn;
    logic [DAY_W-1:0]     mlen_w, mlen_prev, to_next;
    logic [YLEN_W-1:0]    ylen_up, ylen_dn;
    logic [CMP_W-1:0]     n_cmp;
    logic                 year_up_ok, year_dn_ok, load_bad;

    always_comb begin
        leap_w     = is_leap(r_w_ymod);
        ymod_up    = (r_w_ymod == MOD_W'(ERA_YEARS - 1)) ? '0 : r_w_ymod + MOD_W'(1);
        ymod_dn    = (r_w_ymod == '0) ? MOD_W'(ERA_YEARS - 1) : r_w_ymod - MOD_W'(1);
        leap_up    = is_leap(ymod_up);
        leap_dn    = is_leap(ymod_dn);
        mlen_w     = month_len(r_w_month, leap_w);
        mlen_prev  = month_len(r_w_month - MONTH_W'(1), leap_w);
        to_next    = mlen_w - r_w_day + DAY_W'(1);
        feb29      = (r_w_month == MONTH_W'(MONTH_FEB)) && (r_w_day == DAY_W'(FEB_LEAP));
        month_last = (r_w_month == MONTH_W'(MONTHS_YEAR));
        // days to the same date one year on or back
        ylen_up    = YLEN_W'(COMMON_YEAR) +
                     YLEN_W'((r_w_month <= MONTH_W'(MONTH_FEB)) ? leap_w : leap_up);
        ylen_dn    = YLEN_W'(COMMON_YEAR) +
                     YLEN_W'((r_w_month > MONTH_W'(MONTH_FEB)) ? leap_w : leap_dn);
        n_cmp      = CMP_W'(r_n);
        year_up_ok = !feb29 && (r_w_year < YEAR_W'(YEAR_MAX)) &&
                     (n_cmp >= CMP_W'(ylen_up));
        year_dn_ok = !feb29 && (r_w_year != '0) && (n_cmp >= CMP_W'(ylen_dn));
        load_bad   = (r_w_month == '0) || (r_w_month > MONTH_W'(MONTHS_YEAR)) ||
                     (r_w_year > YEAR_W'(YEAR_MAX)) || (r_w_day == '0) ||
                     (r_w_day > mlen_w);
    end

    // month count for month and year steps
    logic signed [TOTAL_W-1:0] tot_y, tot_a, tot_m, tot_base, tot_sum;
    logic                      total_bad;

    always_comb begin
        tot_y = signed'(TOTAL_W'(r_w_year));
        tot_a = TOTAL_W'(r_amount);
        tot_m = signed'(TOTAL_W'(r_w_month - MONTH_W'(1)));
        if (r_act == ACT_MONTHS) begin
            tot_base = tot_y;
            tot_sum  = (tot_base <<< 3) + (tot_base <<< 2) + tot_m + tot_a;
        end else begin
            tot_base = tot_y + tot_a;
            tot_sum  = (tot_base <<< 3) + (tot_base <<< 2) + tot_m;
        end
        total_bad = r_total[TOTAL_W-1] || (r_total > TOTAL_W'(TOTAL_MAX));
    end

    // reciprocal products and their quotients
    logic [DPROD_W-1:0]  div_prod;
    logic [MPROD_W-1:0]  mod_prod;
    logic [YEAR_W-1:0]   q_year;
    logic [MONTHS_W-1:0] q_times12, rem_months;
    logic [ERA_Q_W-1:0]  q_era;
    logic [YEAR_W-1:0]   era_base;

    always_comb begin
        // both factors are zero-extended before the multiply
        div_prod   = DPROD_W'($unsigned(MONTHS_W'(r_total))) *
                     DPROD_W'($unsigned(RECIP_12_W'(RECIP_12)));
        mod_prod   = MPROD_W'(r_w_year) * MPROD_W'($unsigned(RECIP_400_W'(RECIP_400)));
        q_year     = r_prod[RECIP_SHIFT +: YEAR_W];
        q_times12  = (MONTHS_W'(q_year) << 3) + (MONTHS_W'(q_year) << 2);
        rem_months = MONTHS_W'(r_total) - q_times12;
        q_era      = r_prod[RECIP_SHIFT +: ERA_Q_W];
        era_base   = YEAR_W'(q_era * ERA_YEARS);
    end

    // output selection on commit
    logic                 commit_ok;
    logic [DAY_W-1:0]     o_day_sel;
    logic [MONTH_W-1:0]   o_month_sel;
    logic [YEAR_W-1:0]    o_year_sel;
    logic [MOD_W-1:0]     o_ymod_sel;
    logic                 o_leap_sel;

    always_comb begin
        commit_ok   = (r_status == ST_OK);
        o_day_sel   = commit_ok ? r_w_day   : r_day;
        o_month_sel = commit_ok ? r_w_month : r_month;
        o_year_sel  = commit_ok ? r_w_year  : r_year;
        o_ymod_sel  = commit_ok ? r_w_ymod  : r_ymod;
        o_leap_sel  = is_leap(o_ymod_sel);
    end

    // operation decode
    always_comb begin
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_ymod    = r_ymod;
        n_w_day   = r_w_day;
        n_w_month = r_w_month;
        n_w_year  = r_w_year;
        n_w_ymod  = r_w_ymod;
        n_act     = r_act;
        n_status  = r_status;
        n_amount  = r_amount;
        n_dir     = r_dir;
        n_n       = r_n;
        n_total   = r_total;
        n_prod    = r_prod;
        n_odata   = r_odata;
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                n_act    = i_action;
                n_status = ST_OK;
                n_amount = in_amount;
                n_dir    = in_amount[AMOUNT_WIDTH-1];
                n_n      = in_amount[AMOUNT_WIDTH-1] ? AMOUNT_WIDTH'(-in_amount)
                                                     : AMOUNT_WIDTH'(in_amount);
                n_w_ymod = r_ymod;
                if (i_action == ACT_LOAD) begin
                    n_w_day   = in_day;
                    n_w_month = in_month;
                    n_w_year  = in_year;
                end else begin
                    n_w_day   = r_day;
                    n_w_month = r_month;
                    n_w_year  = r_year;
                end
            end
            OP_TOTAL: begin
                n_total = tot_sum;
            end
            OP_DIV: begin
                if (total_bad) begin
                    n_status = ST_RANGE;
                end else begin
                    n_prod = PROD_W'(div_prod);
                end
            end
            OP_SPLIT: begin
                n_w_year  = q_year;
                n_w_month = rem_months[MONTH_W-1:0] + MONTH_W'(1);
            end
            OP_MOD_MUL: begin
                n_prod = PROD_W'(mod_prod);
            end
            OP_MOD_SUB: begin
                n_w_ymod = MOD_W'(r_w_year - era_base);
            end
            OP_CHECK: begin
                if (load_bad) begin
                    n_status = ST_BAD_LOAD;
                end
            end
            OP_FIX: begin
                // day past the new month's end moves to the next month's first
                if (r_w_day > mlen_w) begin
                    n_w_day   = DAY_W'(1);
                    n_w_month = r_w_month + MONTH_W'(1);
                end
            end
            OP_STEP: begin
                if (!r_dir) begin
                    // forward: whole years, then whole months, then days
                    if (year_up_ok) begin
                        n_w_year = r_w_year + YEAR_W'(1);
                        n_w_ymod = ymod_up;
                        n_n      = r_n - AMOUNT_WIDTH'(ylen_up);
                    end else if (n_cmp >= CMP_W'(to_next)) begin
                        n_n     = r_n - AMOUNT_WIDTH'(to_next);
                        n_w_day = DAY_W'(1);
                        if (month_last) begin
                            if (r_w_year == YEAR_W'(YEAR_MAX)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_w_year  = r_w_year + YEAR_W'(1);
                                n_w_ymod  = ymod_up;
                                n_w_month = MONTH_W'(1);
                            end
                        end else begin
                            n_w_month = r_w_month + MONTH_W'(1);
                        end
                    end else begin
                        n_w_day = r_w_day + DAY_W'(r_n);
                        n_n     = '0;
                    end
                end else begin
                    // backward: whole years, then to last day of prior month
                    if (year_dn_ok) begin
                        n_w_year = r_w_year - YEAR_W'(1);
                        n_w_ymod = ymod_dn;
                        n_n      = r_n - AMOUNT_WIDTH'(ylen_dn);
                    end else if (n_cmp >= CMP_W'(r_w_day)) begin
                        n_n = r_n - AMOUNT_WIDTH'(r_w_day);
                        if (r_w_month == MONTH_W'(1)) begin
                            if (r_w_year == '0) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_w_year  = r_w_year - YEAR_W'(1);
                                n_w_ymod  = ymod_dn;
                                n_w_month = MONTH_W'(MONTHS_YEAR);
                                n_w_day   = DAY_W'(LONG_MONTH);
                            end
                        end else begin
                            n_w_month = r_w_month - MONTH_W'(1);
                            n_w_day   = mlen_prev;
                        end
                    end else begin
                        n_w_day = r_w_day - DAY_W'(r_n);
                        n_n     = '0;
                    end
                end
            end
            OP_COMMIT: begin
                if (commit_ok) begin
                    n_day   = r_w_day;
                    n_month = r_w_month;
                    n_year  = r_w_year;
                    n_ymod  = r_w_ymod;
                end
                n_odata = OUT_DATA_W'({r_status,
                                       month_len(o_month_sel, o_leap_sel),
                                       o_leap_sel, o_year_sel, o_month_sel, o_day_sel});
            end
            default: begin
            end
        endcase
    end

    // held date and transaction status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day    <= DAY_W'(1);
            r_month  <= MONTH_W'(1);
            r_year   <= YEAR_W'(YEAR_RESET);
            r_ymod   <= MOD_W'(MOD_RESET);
            r_act    <= ACT_LOAD;
            r_status <= ST_OK;
        end else begin
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_ymod   <= n_ymod;
            r_act    <= n_act;
            r_status <= n_status;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_w_day   <= n_w_day;
        r_w_month <= n_w_month;
        r_w_year  <= n_w_year;
        r_w_ymod  <= n_w_ymod;
        r_amount  <= n_amount;
        r_dir     <= n_dir;
        r_n       <= n_n;
        r_total   <= n_total;
        r_prod    <= n_prod;
        r_odata   <= n_odata;
    end

    assign o_stat.action    = r_act;
    assign o_stat.total_bad = total_bad;
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.err       = (r_status != ST_OK);
    assign o_data           = r_odata;

endmodule

/* rtl/gregorian_date_adder.sv */
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Holds a Gregorian date and loads it or adds signed days, months or years.
// ----------------------------------------------------------------------------
// One transaction at a time. A load captures the fields, reduces the year
// modulo 400 and checks the date; a month or year add goes through month
// count, reciprocal divide by 12, split, modulo 400 reduction and month end
// fix before the result is presented. A day add is walked by a stepper that
// moves one whole year, one month or the final remainder of days per cycle.
// The held date resets to 1/1/1970; a refused transaction leaves it
// untouched and reports status.
// ----------------------------------------------------------------------------
module gregorian_date_adder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: amount, load_day, load_month, load_year
    input  logic [gda_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: action
    input  logic [gda_pkg::ACTION_W-1:0]    i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: day, month, year, leap, month_length, status
    output logic [gda_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import gda_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_action  action;

    assign action = t_action'(i_s_tuser);

    // sequencer
    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (action),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // date datapath
    gda_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_action (action),
        .i_data   (i_s_tdata),
        .o_stat   (stat),
        .o_data   (o_m_tdata)
    );

`ifndef SYNTHESIS
    // one transaction in flight: no second accept right after one
    a_single_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a transaction was in progress");

    // presented date is always a real month and day
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_MONTH_LSB +: MONTH_W] != '0) &&
                       (o_m_tdata[OUT_MONTH_LSB +: MONTH_W] <= MONTH_W'(MONTHS_YEAR)) &&
                       (o_m_tdata[DAY_W-1:0] != '0) &&
                       (o_m_tdata[DAY_W-1:0] <= o_m_tdata[OUT_MLEN_LSB +: DAY_W]))
        else $error("result date out of calendar range");

    // held year never leaves the supported range
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_YEAR_LSB +: YEAR_W] <= YEAR_W'(YEAR_MAX)) &&
                       (o_m_tdata[OUT_STAT_LSB +: STATUS_W] != 2'd3))
        else $error("result year or status out of range");
`endif

endmodule

/* tb/gregorian_date_adder_test.sv */
// ----------------------------------------------------------------------------
// gregorian_date_adder_test
// Drives date loads and day, month and year adds through the input stream and
// checks every result against a calendar predictor kept in a scoreboard.
// A directed block covers field extremes, bad loads, range refusals and month
// end fixes. Four random phases then vary sender gaps and receiver stalls,
// and add a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module gregorian_date_adder_test;

    import gda_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 206;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 200;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int ERA_DAYS     = 146097;
    localparam int SHIFT_YEARS  = 400;

    // one expected result, unpacked
    typedef struct {
        int      day;
        int      month;
        int      year;
        int      leap;
        int      mlen;
        t_status status;
    } t_date_result;

    // calendar predictor and queue of expected results
    class t_date_scoreboard;
        longint       held_day;
        longint       held_month;
        longint       held_year;
        int           failures;
        t_date_result expected_dates[$];

        function new();
            held_day   = 1;
            held_month = 1;
            held_year  = YEAR_RESET;
            failures   = 0;
        endfunction

        function bit leap_year(longint yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        function longint days_in_month(longint mo, longint yr);
            if (mo == 2) return leap_year(yr) ? 29 : 28;
            if (mo <= 7) return (mo % 2 == 0) ? 30 : 31;
            return (mo % 2 == 0) ? 31 : 30;
        endfunction

        // running day count, origin 400 years before year 0
        function longint day_number(longint yr, longint mo, longint dy);
            longint shifted, era, yoe, mp, doy;
            shifted = yr + SHIFT_YEARS - ((mo <= 2) ? 1 : 0);
            era     = shifted / 400;
            yoe     = shifted - era * 400;
            mp      = (mo + 9) % 12;
            doy     = (153 * mp + 2) / 5 + dy - 1;
            return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy;
        endfunction

        function void date_from_number(longint z, output longint yr,
                                       output longint mo, output longint dy);
            longint era, doe, yoe, doy, mp;
            era = z / ERA_DAYS;
            doe = z - era * ERA_DAYS;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            mo  = (mp < 10) ? mp + 3 : mp - 9;
            dy  = doy - (153 * mp + 2) / 5 + 1;
            yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0) - SHIFT_YEARS;
        endfunction

        // accepted input transaction: advance the held date, queue the result
        function void note_input(t_action act, logic signed [AMOUNT_WIDTH-1:0] amt,
                                 logic [DAY_W-1:0] ld, logic [MONTH_W-1:0] lm,
                                 logic [YEAR_W-1:0] ly);
            longint       yr, mo, dy, z, total, delta;
            t_status      st;
            t_date_result want;
            yr    = held_year;
            mo    = held_month;
            dy    = held_day;
            delta = longint'(amt);
            st    = ST_OK;
            case (act)
                ACT_LOAD: begin
                    if (lm < 1 || lm > 12 || ly > YEAR_MAX || ld < 1 ||
                        ld > days_in_month(lm, ly)) begin
                        st = ST_BAD_LOAD;
                    end else begin
                        dy = longint'(ld);
                        mo = longint'(lm);
                        yr = longint'(ly);
                    end
                end
                ACT_DAYS: begin
                    z = day_number(yr, mo, dy) + delta;
                    if (z < day_number(0, 1, 1) || z > day_number(YEAR_MAX, 12, 31)) begin
                        st = ST_RANGE;
                    end else begin
                        date_from_number(z, yr, mo, dy);
                    end
                end
                default: begin
                    if (act == ACT_MONTHS) total = yr * 12 + (mo - 1) + delta;
                    else                   total = (yr + delta) * 12 + (mo - 1);
                    if (total < 0 || total > longint'(YEAR_MAX) * 12 + 11) begin
                        st = ST_RANGE;
                    end else begin
                        yr = total / 12;
                        mo = total % 12 + 1;
                        // day past the new month end moves to the 1st of the next
                        if (dy > days_in_month(mo, yr)) begin
                            dy = 1;
                            mo = mo + 1;
                        end
                    end
                end
            endcase
            if (st == ST_OK) begin
                held_day   = dy;
                held_month = mo;
                held_year  = yr;
            end
            want.day    = int'(held_day);
            want.month  = int'(held_month);
            want.year   = int'(held_year);
            want.leap   = int'(leap_year(held_year));
            want.mlen   = int'(days_in_month(held_month, held_year));
            want.status = st;
            expected_dates.push_back(want);
        endfunction

        function int field_at(logic [OUT_DATA_W-1:0] data, int lsb, int width);
            return int'((data >> lsb) & ((64'd1 << width) - 1));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_date_result want;
            if (expected_dates.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            want = expected_dates.pop_front();
            compare_field("day", want.day, field_at(data, 0, DAY_W));
            compare_field("month", want.month, field_at(data, OUT_MONTH_LSB, MONTH_W));
            compare_field("year", want.year, field_at(data, OUT_YEAR_LSB, YEAR_W));
            compare_field("leap", want.leap, field_at(data, OUT_LEAP_LSB, 1));
            compare_field("month_length", want.mlen, field_at(data, OUT_MLEN_LSB, DAY_W));
            compare_field("status", int'(want.status), field_at(data, OUT_STAT_LSB, STATUS_W));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function void flush_leftovers();
            if (expected_dates.size() != 0) begin
                failures += expected_dates.size();
                $display("%0t: %0d results missing, expected %0d more, actual 0", $time,
                         expected_dates.size(), expected_dates.size());
            end
        endfunction
    endclass

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // tdata: amount, load_day, load_month, load_year
    logic [IN_DATA_W-1:0]    i_s_tdata  = '0;
    // tuser: action
    logic [ACTION_W-1:0]     i_s_tuser  = ACT_LOAD;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // tdata: day, month, year, leap, month_length, status
    logic [OUT_DATA_W-1:0]   o_m_tdata;

    t_date_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    gregorian_date_adder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    // offer one transaction and wait for it to be taken
    task automatic offer(t_action act, logic [AMOUNT_WIDTH-1:0] amt, logic [DAY_W-1:0] ld,
                         logic [MONTH_W-1:0] lm, logic [YEAR_W-1:0] ly);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= IN_DATA_W'({ly, lm, ld, amt});
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(act, amt, ld, lm, ly);
    endtask

    // stop sending until every expected result is back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // random transaction, weighted toward valid loads and modest steps
    task automatic random_item();
        int                      sel, sub;
        logic [AMOUNT_WIDTH-1:0] amt;
        logic [DAY_W-1:0]        ld;
        logic [MONTH_W-1:0]      lm;
        logic [YEAR_W-1:0]       ly;
        int                      len;
        int                      specials [7] = '{0, 1900, 2000, 2100, 2400, 1970, YEAR_MAX};
        sel = $urandom_range(99);
        sub = $urandom_range(9);
        amt = AMOUNT_WIDTH'($urandom());
        ld  = DAY_W'($urandom());
        lm  = MONTH_W'($urandom());
        ly  = YEAR_W'($urandom());
        if (sel < 25) begin
            if (sub != 0) begin
                ly  = YEAR_W'(($urandom_range(3) == 0) ? specials[$urandom_range(6)]
                                                       : $urandom_range(YEAR_MAX));
                lm  = MONTH_W'($urandom_range(12, 1));
                len = int'(sb.days_in_month(lm, ly));
                ld  = DAY_W'($urandom_range(1) ? $urandom_range(len, 1)
                                               : $urandom_range(31, 27));
                if (sub == 1) ld = DAY_W'(len);
            end
            offer(ACT_LOAD, amt, ld, lm, ly);
        end else if (sel < 55) begin
            if (sub >= 4)      amt = AMOUNT_WIDTH'($signed($urandom_range(1600)) - 800);
            else if (sub >= 1) amt = AMOUNT_WIDTH'($signed($urandom_range(120)) - 60);
            offer(ACT_DAYS, amt, ld, lm, ly);
        end else if (sel < 80) begin
            if (sub != 0) amt = AMOUNT_WIDTH'($signed($urandom_range(80)) - 40);
            offer(ACT_MONTHS, amt, ld, lm, ly);
        end else begin
            if (sub != 0) amt = AMOUNT_WIDTH'($signed($urandom_range(60)) - 30);
            offer(ACT_YEARS, amt, ld, lm, ly);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset readback, leap rules, bad loads, range limits
        offer(ACT_DAYS, 16'd0, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd29, 4'd2, 14'd1900);
        offer(ACT_LOAD, 16'hffff, 5'd29, 4'd2, 14'd2000);
        offer(ACT_YEARS, 16'd1, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd31, 4'd1, 14'd2023);
        offer(ACT_MONTHS, 16'd1, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd31, 4'd3, 14'd2024);
        offer(ACT_MONTHS, 16'hffff, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd0, 4'd5, 14'd2020);
        offer(ACT_LOAD, 16'd0, 5'd31, 4'd4, 14'd2020);
        offer(ACT_LOAD, 16'd0, 5'd1, 4'd0, 14'd2020);
        offer(ACT_LOAD, 16'd0, 5'd1, 4'd13, 14'd2020);
        offer(ACT_LOAD, 16'd0, 5'd1, 4'd15, 14'd2020);
        offer(ACT_LOAD, 16'd0, 5'd1, 4'd1, 14'd10000);
        offer(ACT_LOAD, 16'd0, 5'd31, 4'd12, 14'd16383);
        offer(ACT_LOAD, 16'd0, 5'd31, 4'd12, 14'(YEAR_MAX));
        offer(ACT_DAYS, 16'd1, 5'd31, 4'd15, 14'h3fff);
        offer(ACT_MONTHS, 16'd1, 5'd0, 4'd0, 14'd0);
        offer(ACT_YEARS, 16'd1, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd1, 4'd1, 14'd0);
        offer(ACT_DAYS, 16'hffff, 5'd0, 4'd0, 14'd0);
        offer(ACT_DAYS, 16'h7fff, 5'd0, 4'd0, 14'd0);
        offer(ACT_DAYS, 16'h8000, 5'd0, 4'd0, 14'd0);
        offer(ACT_MONTHS, 16'h7fff, 5'd0, 4'd0, 14'd0);
        offer(ACT_YEARS, 16'h8000, 5'd0, 4'd0, 14'd0);
        offer(ACT_LOAD, 16'd0, 5'd28, 4'd2, 14'd2100);
        offer(ACT_DAYS, 16'd1, 5'd0, 4'd0, 14'd0);
        drain();

        // random phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 14 : 0;
            recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 14 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long output hold-off while the sender keeps offering
                if (phase == 0 && n == 60) hold_req <= hold_req + 1;
                if (phase == 0 && n == 120) drain();
                random_item();
            end
            drain();
        end

        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/gda_pkg.sv
rtl/gda_ctrl.sv
rtl/gda_datapath.sv
rtl/gregorian_date_adder.sv
tb/gregorian_date_adder_test.sv
